// ===== hw/rtl/hhfe_pkg.sv =====
`timescale 1ns / 1ps

package hhfe_pkg;

  typedef enum logic [1:0] {
    PH_SEARCHING,
    PH_COPYING,
    PH_ENDED,
    PH_FAILED
  } phase_t;

  localparam logic [1:0] ST_FOUND     = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;

  localparam logic [1:0] CFG_TAG_BYTES     = 2'd0;
  localparam logic [1:0] CFG_TAG_LENGTH    = 2'd1;
  localparam logic [1:0] CFG_MAX_FIELD_LEN = 2'd2;

  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef struct packed {
    logic [7:0]  field_byte;
    logic        has_byte;
    logic        last;
    logic [1:0]  status;
    logic        truncated;
    logic [11:0] field_length;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/hhfe_byte_cell.sv =====
`timescale 1ns / 1ps

module hhfe_byte_cell (
  input  logic               clk,
  input  logic               rst,
  input  hhfe_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]         in_byte,
  input  logic               in_valid,
  input  logic [7:0]         expected,
  input  logic               enable,
  output logic [7:0]         held_byte,
  output logic               held_valid,
  output logic               hit
);
  import hhfe_pkg::*;

  // The compare looks at the value this cell takes on the shift, so a match
  // is known in the same cycle as the byte that completes the tag.
  assign hit = !enable || (in_valid && (in_byte == expected));

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (ctrl.clear) begin
      held_valid <= 1'b0;
    end else if (ctrl.shift) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      held_byte <= 8'd0;
    end else if (ctrl.shift) begin
      held_byte <= in_byte;
    end
  end

endmodule

// ===== hw/rtl/hhfe_result_fifo.sv =====
`timescale 1ns / 1ps

module hhfe_result_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic [1:0]        push_count,
  input  hhfe_pkg::result_t push_first,
  input  hhfe_pkg::result_t push_second,
  output logic              room,
  output logic              pop_valid,
  input  logic              pop_ready,
  output hhfe_pkg::result_t pop_data
);
  import hhfe_pkg::*;

  localparam int DEPTH = 4;

  result_t    entries [DEPTH];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] fill;
  logic       pop;

  // Room for the worst case of one item: a field byte plus a terminator.
  assign room      = (fill <= 3'(DEPTH - 2));
  assign pop_valid = (fill != 3'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if ((push_count != 2'd0) && (2'(i) == wr_ptr)) begin
        entries[i] <= push_first;
      end else if ((push_count == 2'd2) && (2'(i) == 2'(wr_ptr + 2'd1))) begin
        entries[i] <= push_second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      fill   <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push_count;
      if (pop) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      fill <= fill + {1'b0, push_count} - {2'b00, pop};
    end
  end

endmodule

// ===== hw/rtl/http_header_field_extract.sv =====
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// in       in_valid / in_ready    data_byte, end_of_message
// out      out_valid / out_ready  field_byte, has_byte, last, status, truncated, field_length
// cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte is taken per cycle while in_ready is high; its field byte, if any, enters the result queue.
// The last byte of a message adds a terminator item, so that byte can push two
// items into the queue; a four-entry result queue absorbs this.
// in_ready depends only on the queue fill and reset, so output stalls reach the
// input through the registered fill. Reset is synchronous and holds both ready outputs low;
// outside reset the config write port is always ready.
module http_header_field_extract #(
  parameter int MAX_TAG_BYTES   = 8,
  parameter int MAX_FIELD_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  field_byte,
  output logic        has_byte,
  output logic        last,
  output logic [1:0]  status,
  output logic        truncated,
  output logic [11:0] field_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);
  import hhfe_pkg::*;

  localparam logic [3:0]  MAX_TAG_W   = 4'(MAX_TAG_BYTES);
  localparam logic [16:0] MAX_FIELD_W = 17'(MAX_FIELD_BYTES);

  logic [63:0] tag_bytes;
  logic [3:0]  tag_length;
  logic [12:0] max_field_len;

  phase_t      phase;
  phase_t      phase_next;
  logic [11:0] emitted_count;
  logic [11:0] emitted_count_next;
  logic        overflowed;
  logic        overflowed_next;

  logic        accept;
  logic        emit;
  logic        match;
  cell_ctrl_t  ctrl;
  logic [3:0]  tag_len;
  logic [12:0] field_limit;
  result_t     byte_res;
  result_t     term_res;
  result_t     first_res;
  result_t     head;
  logic [1:0]  push_count;
  logic        room;

  logic [7:0]  chain_byte  [MAX_TAG_BYTES];
  logic        chain_valid [MAX_TAG_BYTES];
  logic [MAX_TAG_BYTES-1:0] hits;

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_bytes     <= 64'd0;
      tag_length    <= 4'd6;
      max_field_len <= 13'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TAG_BYTES:     tag_bytes     <= cfg_data;
        CFG_TAG_LENGTH:    tag_length    <= cfg_data[3:0];
        CFG_MAX_FIELD_LEN: max_field_len <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tag_length == 4'd0) begin
      tag_len = 4'd1;
    end else if (tag_length > MAX_TAG_W) begin
      tag_len = MAX_TAG_W;
    end else begin
      tag_len = tag_length;
    end
  end

  always_comb begin
    if ({4'b0000, max_field_len} > MAX_FIELD_W) begin
      field_limit = 13'(MAX_FIELD_BYTES - 1);
    end else if (max_field_len == 13'd0) begin
      field_limit = 13'd0;
    end else begin
      field_limit = max_field_len - 13'd1;
    end
  end

  // Cell k holds the k-th newest byte and checks it against tag byte len-1-k.
  for (genvar k = 0; k < MAX_TAG_BYTES; k++) begin : g_cell
    logic [2:0] sel;
    logic [7:0] expected;
    logic [7:0] in_b;
    logic       in_v;

    assign sel      = 3'(tag_len - 4'd1 - 4'(k));
    assign expected = tag_bytes[{sel, 3'b000} +: 8];

    if (k == 0) begin : g_head
      assign in_b = data_byte;
      assign in_v = 1'b1;
    end else begin : g_tail
      assign in_b = chain_byte[k-1];
      assign in_v = chain_valid[k-1];
    end

    hhfe_byte_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .in_byte    (in_b),
      .in_valid   (in_v),
      .expected   (expected),
      .enable     (4'(k) < tag_len),
      .held_byte  (chain_byte[k]),
      .held_valid (chain_valid[k]),
      .hit        (hits[k])
    );
  end

  assign match  = &hits;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SEARCHING;
      emitted_count <= 12'd0;
      overflowed    <= 1'b0;
    end else begin
      phase         <= phase_next;
      emitted_count <= emitted_count_next;
      overflowed    <= overflowed_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    emitted_count_next = emitted_count;
    overflowed_next    = overflowed;
    emit               = 1'b0;
    ctrl.shift         = 1'b0;
    ctrl.clear         = 1'b0;

    term_res              = '0;
    term_res.last         = 1'b1;

    if (accept) begin
      case (phase)
        PH_SEARCHING: begin
          // A zero byte stops the search for the rest of the message.
          if (data_byte == 8'd0) begin
            phase_next = PH_FAILED;
          end else begin
            ctrl.shift = 1'b1;
            if (match) begin
              phase_next = PH_COPYING;
            end
          end
        end
        PH_COPYING: begin
          if (data_byte == CHAR_CR) begin
            phase_next = PH_ENDED;
          end else if ({1'b0, emitted_count} < field_limit) begin
            emit               = 1'b1;
            emitted_count_next = emitted_count + 12'd1;
          end else begin
            overflowed_next = 1'b1;
          end
        end
        default: ;
      endcase

      if (end_of_message) begin
        if ((phase_next == PH_SEARCHING) || (phase_next == PH_FAILED)) begin
          term_res.status = ST_NOT_FOUND;
        end else if ((emitted_count_next == 12'd0) && !overflowed_next) begin
          term_res.status = ST_EMPTY;
        end else begin
          term_res.status = ST_FOUND;
        end
        term_res.truncated    = overflowed_next;
        term_res.field_length = emitted_count_next;

        ctrl.clear         = 1'b1;
        phase_next         = PH_SEARCHING;
        emitted_count_next = 12'd0;
        overflowed_next    = 1'b0;
      end
    end
  end

  always_comb begin
    byte_res            = '0;
    byte_res.field_byte = data_byte;
    byte_res.has_byte   = 1'b1;
  end

  assign first_res  = emit ? byte_res : term_res;
  assign push_count = 2'(emit) + 2'(accept && end_of_message);

  hhfe_result_fifo u_fifo (
    .clk         (clk),
    .rst         (rst),
    .push_count  (push_count),
    .push_first  (first_res),
    .push_second (term_res),
    .room        (room),
    .pop_valid   (out_valid),
    .pop_ready   (out_ready),
    .pop_data    (head)
  );

  assign in_ready     = room && !rst;
  assign field_byte   = head.field_byte;
  assign has_byte     = head.has_byte;
  assign last         = head.last;
  assign status       = head.status;
  assign truncated    = head.truncated;
  assign field_length = head.field_length;

endmodule

// ===== dv/http_header_field_extract_tb.sv =====
`timescale 1ns / 1ps

module http_header_field_extract_tb;
  import hhfe_pkg::*;

  localparam int TAG_CAP = 8;
  localparam int FIELD_CAP = 4096;
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int ITEMS_PER_PHASE = 230;

  class field_scoreboard;
    logic [63:0] tag_bytes;
    logic [3:0]  tag_len;
    logic [12:0] max_len;
    logic [63:0] recent;
    phase_t      phase;
    int          emitted;
    int          seen;
    bit          overflow;
    result_t     expected_q[$];
    int          errors;
    int          results;
    int          found_cnt;
    int          missing_cnt;
    int          empty_cnt;
    int          trunc_cnt;

    function new();
      tag_bytes = '0;
      tag_len = 4'd6;
      max_len = 13'd256;
      errors = 0;
      results = 0;
      found_cnt = 0;
      missing_cnt = 0;
      empty_cnt = 0;
      trunc_cnt = 0;
      clear_message();
    endfunction

    function void clear_message();
      recent = '0;
      phase = PH_SEARCHING;
      emitted = 0;
      seen = 0;
      overflow = 1'b0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [63:0] value);
      case (idx)
        CFG_TAG_BYTES: tag_bytes = value;
        CFG_TAG_LENGTH: tag_len = value[3:0];
        CFG_MAX_FIELD_LEN: max_len = value[12:0];
        default: ;
      endcase
    endfunction

    function int eff_tag_len();
      int n;
      n = tag_len;
      if (n < 1) n = 1;
      if (n > TAG_CAP) n = TAG_CAP;
      return n;
    endfunction

    function int field_limit();
      int m;
      m = max_len;
      if (m > FIELD_CAP) m = FIELD_CAP;
      return (m > 0) ? m - 1 : 0;
    endfunction

    // The first tag character must line up with the oldest of the last n bytes.
    function bit tag_hit();
      int n;
      int i;
      n = eff_tag_len();
      if (seen < n) return 1'b0;
      for (i = 0; i < n; i++) begin
        if (tag_bytes[8*i +: 8] != recent[8*(n-1-i) +: 8]) return 1'b0;
      end
      return 1'b1;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [7:0] b, logic eom);
      result_t r;
      case (phase)
        PH_SEARCHING: begin
          if (b == 8'h00) begin
            phase = PH_FAILED;
          end else begin
            recent = {recent[55:0], b};
            if (seen < 8) seen++;
            if (tag_hit()) phase = PH_COPYING;
          end
        end
        PH_COPYING: begin
          if (b == CHAR_CR) begin
            phase = PH_ENDED;
          end else if (emitted < field_limit()) begin
            r = '0;
            r.field_byte = b;
            r.has_byte = 1'b1;
            expected_q.push_back(r);
            emitted = (emitted + 1) & 12'hFFF;
          end else begin
            overflow = 1'b1;
          end
        end
        default: ;
      endcase
      if (eom) begin
        r = '0;
        r.last = 1'b1;
        r.truncated = overflow;
        r.field_length = emitted[11:0];
        if (phase == PH_SEARCHING || phase == PH_FAILED) r.status = ST_NOT_FOUND;
        else if (emitted == 0 && !overflow) r.status = ST_EMPTY;
        else r.status = ST_FOUND;
        expected_q.push_back(r);
        clear_message();
      end
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        errors++;
        $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      end
    endfunction

    function void check_result(logic [7:0] fb, logic hb, logic la, logic [1:0] st,
                               logic tr, logic [11:0] fl);
      result_t want;
      results++;
      if (expected_q.size() == 0) begin
        errors++;
        $error("result item with no expectation: field_byte %0h last %0b", fb, la);
        return;
      end
      want = expected_q.pop_front();
      compare_field("field_byte", want.field_byte, fb);
      compare_field("has_byte", want.has_byte, hb);
      compare_field("last", want.last, la);
      compare_field("status", want.status, st);
      compare_field("truncated", want.truncated, tr);
      compare_field("field_length", want.field_length, fl);
      if (want.last) begin
        if (want.status == ST_FOUND) found_cnt++;
        else if (want.status == ST_NOT_FOUND) missing_cnt++;
        else empty_cnt++;
        if (want.truncated) trunc_cnt++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  field_byte;
  logic        has_byte;
  logic        last;
  logic [1:0]  status;
  logic        truncated;
  logic [11:0] field_length;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  field_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int items_sent = 0;
  int settings_used = 0;

  http_header_field_extract dut (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $error("timeout with %0d result items still expected", sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready)
        sb.check_result(field_byte, has_byte, last, status, truncated, field_length);
      if (in_valid && in_ready) sb.note_input(data_byte, end_of_message);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eom);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    int k;
    for (k = 0; k < msg.size(); k++) send_item(msg[k], k == msg.size() - 1);
  endtask

  // Let every outstanding item come back, then wait out items that
  // produce no result but may still be inside the block.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Upper bits of the narrow registers carry junk, which the block must drop.
  task automatic program_cfg(input logic [63:0] tag, input logic [3:0] len,
                             input logic [12:0] max_len, input bit poke_unused);
    drain();
    write_cfg(CFG_TAG_BYTES, tag);
    write_cfg(CFG_TAG_LENGTH, {32'($urandom()), 28'h0, len});
    write_cfg(CFG_MAX_FIELD_LEN, {32'($urandom()), 19'h0, max_len});
    if (poke_unused) write_cfg(CFG_UNUSED, {$urandom(), $urandom()});
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  function automatic logic [63:0] random_tag();
    logic [63:0] t;
    int i;
    for (i = 0; i < 8; i++) t[8*i +: 8] = 8'($urandom_range(1, 255));
    return t;
  endfunction

  // Mostly prefix, tag, field and sometimes an ending; some messages carry a damaged
  // tag, and the rest are plain noise.
  task automatic send_random_message();
    logic [7:0] msg[$];
    int n;
    int kind;
    int top;
    int flen;
    int pos;
    int k;
    n = sb.eff_tag_len();
    kind = $urandom_range(0, 99);
    if (kind < 80) begin
      repeat ($urandom_range(0, 5)) msg.push_back(8'($urandom_range(1, 255)));
      pos = msg.size();
      for (k = 0; k < n; k++) msg.push_back(sb.tag_bytes[8*k +: 8]);
      if (kind >= 65) begin
        k = $urandom_range(0, n - 1);
        msg[pos + k] = msg[pos + k] ^ 8'($urandom_range(1, 255));
      end
      top = sb.field_limit() + 2;
      if (top > 10) top = 10;
      flen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, top);
      repeat (flen) msg.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) begin
        msg.push_back(CHAR_CR);
        repeat ($urandom_range(0, 3)) msg.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      repeat ($urandom_range(1, 12)) begin
        if ($urandom_range(0, 7) == 0) msg.push_back(8'h00);
        else msg.push_back(8'($urandom_range(0, 255)));
      end
    end
    send_message(msg);
  endtask

  initial begin
    logic [7:0]  msg[$];
    logic [63:0] t;
    int p;
    int phase_start;
    sb = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // With the reset registers the tag is all zero bytes and can never match.
    msg = '{"G", "E"};
    send_message(msg);

    program_cfg(64'h3A48, 4'd2, 13'd3, 1'b0);
    msg = '{"H", ":"};
    send_message(msg);
    msg = '{"H", ":", 8'h00, 8'hFF, 8'h41};
    send_message(msg);
    msg = '{8'h00, "H", ":", "x"};
    send_message(msg);
    msg = '{"H", ":", CHAR_CR, "q"};
    send_message(msg);

    // A tag length of zero acts as one, and a zero buffer passes nothing on.
    program_cfg(64'h5A, 4'd0, 13'd0, 1'b0);
    msg = '{"Z", "Z", "q"};
    send_message(msg);
    msg = '{"Z"};
    send_message(msg);

    for (p = 0; p < 8; p++) begin
      case (p)
        0: program_cfg(64'h0000_203A_7473_6F48, 4'd6, 13'd256, 1'b0);
        1: program_cfg(random_tag(), 4'd8, 13'd4096, 1'b0);
        2: program_cfg(random_tag(), 4'd1, 13'd2, 1'b0);
        3: program_cfg(random_tag(), 4'd0, 13'd0, 1'b0);
        4: program_cfg(random_tag(), 4'd15, 13'd8191, 1'b0);
        5: begin
          t = random_tag();
          t[23:16] = 8'h00;
          program_cfg(t, 4'd4, 13'd5, 1'b0);
        end
        6: program_cfg(random_tag(), 4'd3, 13'd1, 1'b0);
        default: program_cfg(random_tag(), 4'd5, 13'd7, 1'b1);
      endcase
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct = 81;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 81;
        end
        default: begin
          idle_pct = 6;
          stall_pct <= 6;
        end
      endcase
      phase_start = items_sent;
      while (items_sent < phase_start + ITEMS_PER_PHASE) send_random_message();
    end

    drain();
    $display("Sent %0d bytes under %0d register settings; checked %0d result items.",
             items_sent, settings_used, sb.results);
    $display("Messages ended with %0d found, %0d not found, %0d empty, %0d truncated.",
             sb.found_cnt, sb.missing_cnt, sb.empty_cnt, sb.trunc_cnt);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
